[hw/rtl/assert_macros.svh]
// Assertion helpers used by acfe_symbol_gen. Empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every rising clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

[hw/rtl/acfe_pkg.sv]
`default_nettype none

package acfe_pkg;

    localparam int FRAME_BYTES = 14;
    localparam int SECTION_BYTES = 7;
    localparam int FRAME_BITS = FRAME_BYTES * 8;

    typedef logic [FRAME_BITS-1:0] frame_t;
    typedef logic [6:0] sym_idx_t;
    typedef logic [2:0] cfg_idx_t;
    typedef logic [5:0] cfg_data_t;

    // Register indexes on the configuration port
    localparam cfg_idx_t CFG_POWER_ON         = 3'd0;
    localparam cfg_idx_t CFG_SET_TEMPERATURE  = 3'd1;
    localparam cfg_idx_t CFG_OP_MODE          = 3'd2;
    localparam cfg_idx_t CFG_FAN_SPEED        = 3'd3;
    localparam cfg_idx_t CFG_SWING_HORIZONTAL = 3'd4;
    localparam cfg_idx_t CFG_SWING_VERTICAL   = 3'd5;

    typedef struct packed {
        logic       power_on;
        logic [5:0] set_temperature;
        logic [2:0] op_mode;
        logic [1:0] fan_speed;
        logic       swing_horizontal;
        logic       swing_vertical;
    } cfg_t;

    localparam logic [5:0] TEMP_RESET = 6'd24;
    localparam logic [5:0] TEMP_MIN   = 6'd16;
    localparam logic [5:0] TEMP_MAX   = 6'd30;

    localparam logic [7:0] BASE_FRAME [FRAME_BYTES] = '{
        8'h02, 8'h92, 8'h0F, 8'h00, 8'h00, 8'h00, 8'hF0,
        8'h01, 8'h02, 8'hAE, 8'h71, 8'h00, 8'h15, 8'hF0
    };

    // Symbol positions within one frame
    localparam sym_idx_t PAIRS_PER_FRAME = 7'd117;
    localparam sym_idx_t SYM_LEAD_IN     = 7'd0;
    localparam sym_idx_t SYM_HDR_0       = 7'd1;
    localparam sym_idx_t SYM_GAP_0       = 7'd58;
    localparam sym_idx_t SYM_HDR_1       = 7'd59;
    localparam sym_idx_t SYM_GAP_1       = 7'd116;
    localparam sym_idx_t SYM_LAST        = 7'd116;
    localparam sym_idx_t DATA_OFS_0      = 7'd2;
    localparam sym_idx_t DATA_OFS_1      = 7'd4;

    // Pulse timings in microseconds
    localparam logic [11:0] LEAD_MARK_US  = 12'd690;
    localparam logic [14:0] LEAD_SPACE_US = 15'd17844;
    localparam logic [11:0] HDR_MARK_US   = 12'd3086;
    localparam logic [14:0] HDR_SPACE_US  = 15'd8864;
    localparam logic [11:0] BIT_MARK_US   = 12'd586;
    localparam logic [14:0] ONE_SPACE_US  = 15'd1432;
    localparam logic [14:0] ZERO_SPACE_US = 15'd436;
    localparam logic [14:0] GAP_SPACE_US  = 15'd2886;

    function automatic logic [2:0] mode_code(input logic [2:0] op_mode);
        logic [2:0] code;
        case (op_mode)
            3'd0:    code = 3'd0;
            3'd1:    code = 3'd1;
            3'd2:    code = 3'd4;
            3'd3:    code = 3'd2;
            3'd4:    code = 3'd3;
            default: code = 3'd0;
        endcase
        return code;
    endfunction

    function automatic logic [2:0] fan_code(input logic [1:0] fan_speed);
        logic [2:0] code;
        case (fan_speed)
            2'd0:    code = 3'd0;
            2'd1:    code = 3'd2;
            2'd2:    code = 3'd4;
            default: code = 3'd5;
        endcase
        return code;
    endfunction

    function automatic logic [2:0] swing_code(input logic h, input logic v);
        logic [2:0] code;
        case ({h, v})
            2'b00:   code = 3'd7;
            2'b01:   code = 3'd2;
            2'b10:   code = 3'd3;
            default: code = 3'd4;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] temp_code(input logic [5:0] t);
        logic [5:0] tc;
        logic [5:0] ofs;
        tc = t;
        if (t < TEMP_MIN)
        begin
            tc = TEMP_MIN;
        end
        else if (t > TEMP_MAX)
        begin
            tc = TEMP_MAX;
        end
        ofs = tc - TEMP_MIN;
        return ofs[3:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/acfe_frame_builder.sv]
`default_nettype none

module acfe_frame_builder (
    input  acfe_pkg::cfg_t   cfg,
    output acfe_pkg::frame_t frame
);
    import acfe_pkg::*;

    logic [7:0] pre [FRAME_BYTES];
    logic [7:0] fin [FRAME_BYTES];
    logic [7:0] sum0;
    logic [7:0] sum1;

    function automatic logic [3:0] ones8(input logic [7:0] v);
        logic [3:0] c;
        c = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + {3'b000, v[i]};
        end
        return c;
    endfunction

    // Count over byte 0, low nibble of byte 1, high nibble of byte 2 and bytes 3..6
    function automatic logic [7:0] section_sum(input logic [7:0] b0, input logic [7:0] b1,
                                               input logic [7:0] b2, input logic [7:0] b3,
                                               input logic [7:0] b4, input logic [7:0] b5,
                                               input logic [7:0] b6);
        logic [5:0] c;
        c = {2'b00, ones8(b0)} + {2'b00, ones8(b1 & 8'h0F)} + {2'b00, ones8(b2 & 8'hF0)}
          + {2'b00, ones8(b3)} + {2'b00, ones8(b4)} + {2'b00, ones8(b5)}
          + {2'b00, ones8(b6)};
        return ~{2'b00, c};
    endfunction

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            pre[i] = BASE_FRAME[i];
        end
        pre[9][6:4]  = swing_code(cfg.swing_horizontal, cfg.swing_vertical);
        pre[6][5:4]  = {2{cfg.power_on}};
        pre[13][5:4] = {2{cfg.power_on}};
        pre[12][6:4] = mode_code(cfg.op_mode);
        pre[12][3:1] = fan_code(cfg.fan_speed);
        pre[11][7:4] = temp_code(cfg.set_temperature);
        pre[13][2]   = 1'b1;
    end

    assign sum0 = section_sum(pre[0], pre[1], pre[2], pre[3], pre[4], pre[5], pre[6]);
    assign sum1 = section_sum(pre[7], pre[8], pre[9], pre[10], pre[11], pre[12], pre[13]);

    // Drop the checksum nibbles into their slots; the counted bits are untouched
    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            fin[i] = pre[i];
        end
        fin[1][7:4] = sum0[3:0];
        fin[2][3:0] = sum0[7:4];
        fin[SECTION_BYTES + 1][7:4] = sum1[3:0];
        fin[SECTION_BYTES + 2][3:0] = sum1[7:4];
    end

    always_comb
    begin
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            frame[i*8 +: 8] = fin[i];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/acfe_symbol_gen.sv]
`default_nettype none

`include "assert_macros.svh"

module acfe_symbol_gen (
    input  wire              clk,
    input  wire              rst_n,
    input  acfe_pkg::frame_t frame,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire              restart,
    output logic             out_valid,
    input  wire              out_ready,
    output logic [11:0]      mark_us,
    output logic [14:0]      space_us,
    output logic             frame_end
);
    import acfe_pkg::*;

    sym_idx_t    idx_reg;
    sym_idx_t    idx_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [11:0] mark_reg;
    logic [11:0] mark_next;
    logic [14:0] space_reg;
    logic [14:0] space_next;
    logic        frame_end_reg;
    logic        frame_end_next;

    logic        in_fire;
    sym_idx_t    sym;
    sym_idx_t    bit_idx;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        sym = idx_reg;
        if (restart || idx_reg >= PAIRS_PER_FRAME)
        begin
            sym = SYM_LEAD_IN;
        end
        bit_idx = (sym < SYM_GAP_0) ? (sym - DATA_OFS_0) : (sym - DATA_OFS_1);
    end

    always_comb
    begin
        mark_next      = BIT_MARK_US;
        space_next     = frame[bit_idx] ? ONE_SPACE_US : ZERO_SPACE_US;
        frame_end_next = (sym == SYM_LAST);
        if (sym == SYM_LEAD_IN)
        begin
            mark_next  = LEAD_MARK_US;
            space_next = LEAD_SPACE_US;
        end
        else if (sym == SYM_HDR_0 || sym == SYM_HDR_1)
        begin
            mark_next  = HDR_MARK_US;
            space_next = HDR_SPACE_US;
        end
        else if (sym == SYM_GAP_0 || sym == SYM_GAP_1)
        begin
            space_next = GAP_SPACE_US;
        end
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (in_fire)
        begin
            out_valid_next = 1'b1;
            idx_next       = (sym == SYM_LAST) ? SYM_LEAD_IN : sym + 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= SYM_LEAD_IN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload loads only on an accepted transaction
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mark_reg      <= mark_next;
            space_reg     <= space_next;
            frame_end_reg <= frame_end_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign mark_us   = mark_reg;
    assign space_us  = space_reg;
    assign frame_end = frame_end_reg;

    `ASSERT_ALWAYS(a_idx_range, clk, rst_n, idx_reg < PAIRS_PER_FRAME, "symbol index out of range")
    `ASSERT_NEXT(a_wrap, clk, rst_n, in_fire && sym == SYM_LAST, idx_reg == SYM_LEAD_IN, "no wrap after last pair")
    `ASSERT_NEXT(a_advance, clk, rst_n, in_fire && !restart && idx_reg < SYM_LAST, idx_reg == $past(idx_reg) + 7'd1, "index did not advance")
    `ASSERT_NEXT(a_result, clk, rst_n, in_fire, out_valid_reg, "accepted transaction gave no result")
    `ASSERT_IMPLIES(a_end_gap, clk, rst_n, out_valid_reg && frame_end_reg, mark_reg == BIT_MARK_US && space_reg == GAP_SPACE_US, "frame end not on a gap pair")

endmodule

`default_nettype wire

[hw/rtl/ac_ir_frame_pulse_encoder_top.sv]
// A result is valid the cycle after its input transaction is accepted.
// Throughput: one pulse pair per cycle while in_valid and out_ready stay high; the symbol
// counter and the output register advance together, with the frame rebuilt by logic from the settings.
// Reset: rst_n (asynchronous, active low) clears the symbol counter to the
// lead-in, empties the output register and loads the setting reset values.
`default_nettype none

module ac_ir_frame_pulse_encoder_top (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  acfe_pkg::cfg_idx_t  cfg_index,
    input  acfe_pkg::cfg_data_t cfg_data,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire                 restart,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [11:0]         mark_us,
    output logic [14:0]         space_us,
    output logic                frame_end
);
    import acfe_pkg::*;

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    frame_t frame;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_POWER_ON:         cfg_next.power_on         = cfg_data[0];
                CFG_SET_TEMPERATURE:  cfg_next.set_temperature  = cfg_data;
                CFG_OP_MODE:          cfg_next.op_mode          = cfg_data[2:0];
                CFG_FAN_SPEED:        cfg_next.fan_speed        = cfg_data[1:0];
                CFG_SWING_HORIZONTAL: cfg_next.swing_horizontal = cfg_data[0];
                CFG_SWING_VERTICAL:   cfg_next.swing_vertical   = cfg_data[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on         <= 1'b0;
            cfg_reg.set_temperature  <= TEMP_RESET;
            cfg_reg.op_mode          <= 3'd0;
            cfg_reg.fan_speed        <= 2'd0;
            cfg_reg.swing_horizontal <= 1'b0;
            cfg_reg.swing_vertical   <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    acfe_frame_builder u_frame_builder (
        .cfg   (cfg_reg),
        .frame (frame)
    );

    acfe_symbol_gen u_symbol_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .mark_us   (mark_us),
        .space_us  (space_us),
        .frame_end (frame_end)
    );

endmodule

`default_nettype wire
